### hdl/rpj_pkg.sv
// Shared saturating fixed-point helpers and register indexes for the reprojection core.
package rpj_pkg;

  localparam logic [1:0] IDX_INFO_00 = 2'd0;
  localparam logic [1:0] IDX_INFO_01 = 2'd1;
  localparam logic [1:0] IDX_INFO_10 = 2'd2;
  localparam logic [1:0] IDX_INFO_11 = 2'd3;
  localparam int NUM_INFO = 4;
  localparam int NUM_COLS = 10;

  function automatic logic signed [63:0] f_sat(input logic signed [63:0] x, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic logic signed [63:0] f_add(input logic signed [63:0] a,
                                               input logic signed [63:0] b, input int w);
    return f_sat(a + b, w);
  endfunction

  function automatic logic signed [63:0] f_sub(input logic signed [63:0] a,
                                               input logic signed [63:0] b, input int w);
    return f_sat(a - b, w);
  endfunction

  function automatic logic signed [63:0] f_neg(input logic signed [63:0] a, input int w);
    return f_sat(-a, w);
  endfunction

  function automatic logic signed [63:0] f_dbl(input logic signed [63:0] a, input int w);
    return f_sat(a + a, w);
  endfunction

  // product rounded to nearest, ties away from zero
  function automatic logic signed [63:0] f_mul(input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               input int w, input int f);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [63:0] r;
    logic        n;
    n  = a[63] ^ b[63];
    ma = a[63] ? 32'(-a) : 32'(a);
    mb = b[63] ? 32'(-b) : 32'(b);
    p  = ma * mb;
    r  = (p + (64'd1 << (f - 1))) >> f;
    return f_sat(n ? -$signed(r) : $signed(r), w);
  endfunction

endpackage

### hdl/pinhole_reprojection_residual_jacobian_core.sv
// Pinhole reprojection residual and Jacobian core: one observation in, two result rows out.
// Each transfer in yields two result transfers, the u row (last_row low) and then the v row,
// so at full rate a new observation enters only as the v row of the last one is sent; the
// single result register that sends both rows sets that limit. The path to the u row runs
// through four transform stages, two 1-bit-per-stage divider pipelines of DATA_WIDTH + 3
// stages each for DATA_WIDTH up to 32, four Jacobian stages and the result register. in_stall
// rises only while a finished observation waits in the result register; the whole pipeline
// then holds. Write the information matrix over APB only while idle; the core does not check.
module pinhole_reprojection_residual_jacobian_core import rpj_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] cam_pos_x,
  input  logic signed [31:0] cam_pos_y,
  input  logic signed [31:0] cam_pos_z,
  input  logic signed [17:0] quat_x,
  input  logic signed [17:0] quat_y,
  input  logic signed [17:0] quat_z,
  input  logic signed [17:0] quat_w,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] observed_u,
  input  logic signed [31:0] observed_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] residual,
  output logic signed [31:0] pose_jac_tx,
  output logic signed [31:0] pose_jac_ty,
  output logic signed [31:0] pose_jac_tz,
  output logic signed [31:0] pose_jac_rx,
  output logic signed [31:0] pose_jac_ry,
  output logic signed [31:0] pose_jac_rz,
  output logic signed [31:0] point_jac_x,
  output logic signed [31:0] point_jac_y,
  output logic signed [31:0] point_jac_z,
  output logic               depth_invalid,
  output logic               last_row
);

  localparam int W    = DATA_WIDTH > 32 ? 32 : DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int SA_W = 14 * W + 1;
  localparam int SB_W = 15 * W + 1;
  localparam logic signed [W-1:0] HI = {1'b0, {(W-1){1'b1}}};

  logic adv;
  logic signed [W-1:0] info [NUM_INFO];

  logic                fr_vld, fr_bad;
  logic signed [W-1:0] fr_rot [9];
  logic signed [W-1:0] fr_cam [3];
  logic signed [W-1:0] fr_ou, fr_ov;

  logic signed [W-1:0] da_num [3];
  logic signed [W-1:0] da_quo [3];
  logic [SA_W-1:0]     sa_in, sa_out;
  logic                da_vld;

  logic signed [W-1:0] db_num [2];
  logic signed [W-1:0] db_quo [2];
  logic [SB_W-1:0]     sb_in, sb_out;
  logic                db_vld;
  logic signed [W-1:0] a_rot [9];
  logic signed [W-1:0] a_cam [3];
  logic signed [W-1:0] b_rot [9];
  logic signed [W-1:0] b_cam [3];

  logic                bk_vld, bk_bad;
  logic signed [W-1:0] bk_row [2][NUM_COLS];

  logic signed [W-1:0] row0 [NUM_COLS];
  logic signed [W-1:0] row1 [NUM_COLS];
  logic signed [W-1:0] osel [NUM_COLS];

  assign adv      = !out_valid || (!out_stall && last_row);
  assign in_stall = !adv;

  rpj_cfg #(.W(W), .F(F)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .info
  );

  rpj_front #(.W(W), .F(F)) u_front (
    .clk, .rst, .adv, .in_vld(in_valid),
    .cam_pos_x, .cam_pos_y, .cam_pos_z, .quat_x, .quat_y, .quat_z, .quat_w,
    .point_x, .point_y, .point_z, .observed_u, .observed_v,
    .out_vld(fr_vld), .rot(fr_rot), .cam(fr_cam), .obs_u(fr_ou), .obs_v(fr_ov), .bad(fr_bad)
  );

  always_comb begin
    da_num[0] = W'(f_sat(64'sd1 <<< F, W));
    da_num[1] = fr_cam[0];
    da_num[2] = fr_cam[1];
    for (int k = 0; k < 9; k++) sa_in[k*W +: W] = fr_rot[k];
    for (int k = 0; k < 3; k++) sa_in[(9+k)*W +: W] = fr_cam[k];
    sa_in[12*W +: W] = fr_ou;
    sa_in[13*W +: W] = fr_ov;
    sa_in[14*W]      = fr_bad;
  end

  rpj_div #(.W(W), .F(F), .LANES(3), .SIDE_W(SA_W)) u_div_a (
    .clk, .rst, .adv, .in_vld(fr_vld), .num(da_num), .den(fr_cam[2]), .side_in(sa_in),
    .out_vld(da_vld), .quo(da_quo), .side_out(sa_out)
  );

  always_comb begin
    for (int k = 0; k < 9; k++) a_rot[k] = $signed(sa_out[k*W +: W]);
    for (int k = 0; k < 3; k++) a_cam[k] = $signed(sa_out[(9+k)*W +: W]);
    db_num[0] = da_quo[1];
    db_num[1] = da_quo[2];
    for (int k = 0; k < 9; k++) sb_in[k*W +: W] = a_rot[k];
    for (int k = 0; k < 3; k++) sb_in[(9+k)*W +: W] = a_cam[k];
    sb_in[12*W +: W] = da_quo[0];
    sb_in[13*W +: W] = W'(f_sub(da_quo[1], $signed(sa_out[12*W +: W]), W));
    sb_in[14*W +: W] = W'(f_sub(da_quo[2], $signed(sa_out[13*W +: W]), W));
    sb_in[15*W]      = sa_out[14*W];
  end

  rpj_div #(.W(W), .F(F), .LANES(2), .SIDE_W(SB_W)) u_div_b (
    .clk, .rst, .adv, .in_vld(da_vld), .num(db_num), .den(a_cam[2]), .side_in(sb_in),
    .out_vld(db_vld), .quo(db_quo), .side_out(sb_out)
  );

  always_comb begin
    for (int k = 0; k < 9; k++) b_rot[k] = $signed(sb_out[k*W +: W]);
    for (int k = 0; k < 3; k++) b_cam[k] = $signed(sb_out[(9+k)*W +: W]);
  end

  rpj_back #(.W(W), .F(F)) u_back (
    .clk, .rst, .adv, .in_vld(db_vld), .info,
    .iz($signed(sb_out[12*W +: W])), .eu($signed(sb_out[13*W +: W])),
    .ev($signed(sb_out[14*W +: W])), .uz(db_quo[0]), .vz(db_quo[1]),
    .rot(b_rot), .cam(b_cam), .bad_in(sb_out[15*W]),
    .out_vld(bk_vld), .row_val(bk_row), .bad(bk_bad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_row  <= 1'b0;
    end else if (adv) begin
      out_valid <= bk_vld;
      last_row  <= 1'b0;
    end else if (!out_stall) begin
      last_row <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_COLS; k++) begin
        row0[k] <= bk_bad ? HI : bk_row[0][k];
        row1[k] <= bk_bad ? HI : bk_row[1][k];
      end
      depth_invalid <= bk_bad;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COLS; k++) osel[k] = last_row ? row1[k] : row0[k];
  end

  assign residual    = 32'(osel[0]);
  assign pose_jac_tx = 32'(osel[1]);
  assign pose_jac_ty = 32'(osel[2]);
  assign pose_jac_tz = 32'(osel[3]);
  assign pose_jac_rx = 32'(osel[4]);
  assign pose_jac_ry = 32'(osel[5]);
  assign pose_jac_rz = 32'(osel[6]);
  assign point_jac_x = 32'(osel[7]);
  assign point_jac_y = 32'(osel[8]);
  assign point_jac_z = 32'(osel[9]);

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result register");

  a_v_row_follows_u_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_row |=> out_valid && last_row)
    else $error("v row did not follow the u row transfer");

  a_bad_depth_saturates: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_invalid |-> residual == 32'(HI) && point_jac_z == 32'(HI))
    else $error("invalid depth result not saturated");

  a_row_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(last_row))
    else $error("row select moved while stalled");

endmodule

### hdl/rpj_cfg.sv
// APB register file holding the square root information matrix.
module rpj_cfg import rpj_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic signed [W-1:0] info [NUM_INFO]
);

  logic [31:0] info_reg [NUM_INFO];

  always_ff @(posedge clk) begin
    if (rst) begin
      info_reg[IDX_INFO_00] <= 32'd1 << F;
      info_reg[IDX_INFO_01] <= '0;
      info_reg[IDX_INFO_10] <= '0;
      info_reg[IDX_INFO_11] <= 32'd1 << F;
    end else if (psel && penable && pwrite) begin
      info_reg[paddr[3:2]] <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = info_reg[paddr[3:2]];

  always_comb begin
    for (int k = 0; k < NUM_INFO; k++) begin
      info[k] = W'(f_sat($signed(info_reg[k]), W));
    end
  end

endmodule

### hdl/rpj_front.sv
// Rotation build and world-to-camera transform, four pipeline stages.
module rpj_front import rpj_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic signed [31:0]  cam_pos_x,
  input  logic signed [31:0]  cam_pos_y,
  input  logic signed [31:0]  cam_pos_z,
  input  logic signed [17:0]  quat_x,
  input  logic signed [17:0]  quat_y,
  input  logic signed [17:0]  quat_z,
  input  logic signed [17:0]  quat_w,
  input  logic signed [31:0]  point_x,
  input  logic signed [31:0]  point_y,
  input  logic signed [31:0]  point_z,
  input  logic signed [31:0]  observed_u,
  input  logic signed [31:0]  observed_v,
  output logic                out_vld,
  output logic signed [W-1:0] rot [9],
  output logic signed [W-1:0] cam [3],
  output logic signed [W-1:0] obs_u,
  output logic signed [W-1:0] obs_v,
  output logic                bad
);

  logic signed [63:0] one;
  logic signed [63:0] qx, qy, qz, qw;
  logic v1, v2, v3;
  logic signed [W-1:0] d1 [3];
  logic signed [W-1:0] qp [9];
  logic signed [W-1:0] ou1, ov1, ou2, ov2, ou3, ov3;
  logic signed [W-1:0] d2 [3];
  logic signed [W-1:0] r2 [9];
  logic signed [W-1:0] r3 [9];
  logic signed [W-1:0] pr3 [3][3];
  logic signed [63:0] cz;

  assign one = f_sat(64'sd1 <<< F, W);
  assign qx  = f_sat(quat_x, W);
  assign qy  = f_sat(quat_y, W);
  assign qz  = f_sat(quat_z, W);
  assign qw  = f_sat(quat_w, W);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      out_vld <= v3;
    end
  end

  assign cz = f_add(f_add(pr3[2][0], pr3[2][1], W), pr3[2][2], W);

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= W'(f_sub(f_sat(point_x, W), f_sat(cam_pos_x, W), W));
      d1[1] <= W'(f_sub(f_sat(point_y, W), f_sat(cam_pos_y, W), W));
      d1[2] <= W'(f_sub(f_sat(point_z, W), f_sat(cam_pos_z, W), W));
      qp[0] <= W'(f_mul(qx, qx, W, F));
      qp[1] <= W'(f_mul(qy, qy, W, F));
      qp[2] <= W'(f_mul(qz, qz, W, F));
      qp[3] <= W'(f_mul(qx, qy, W, F));
      qp[4] <= W'(f_mul(qz, qw, W, F));
      qp[5] <= W'(f_mul(qx, qz, W, F));
      qp[6] <= W'(f_mul(qy, qw, W, F));
      qp[7] <= W'(f_mul(qy, qz, W, F));
      qp[8] <= W'(f_mul(qx, qw, W, F));
      ou1 <= W'(f_sat(observed_u, W));
      ov1 <= W'(f_sat(observed_v, W));

      r2[0] <= W'(f_sub(one, f_dbl(f_add(qp[1], qp[2], W), W), W));
      r2[1] <= W'(f_dbl(f_sub(qp[3], qp[4], W), W));
      r2[2] <= W'(f_dbl(f_add(qp[5], qp[6], W), W));
      r2[3] <= W'(f_dbl(f_add(qp[3], qp[4], W), W));
      r2[4] <= W'(f_sub(one, f_dbl(f_add(qp[0], qp[2], W), W), W));
      r2[5] <= W'(f_dbl(f_sub(qp[7], qp[8], W), W));
      r2[6] <= W'(f_dbl(f_sub(qp[5], qp[6], W), W));
      r2[7] <= W'(f_dbl(f_add(qp[7], qp[8], W), W));
      r2[8] <= W'(f_sub(one, f_dbl(f_add(qp[0], qp[1], W), W), W));
      d2 <= d1;
      ou2 <= ou1;
      ov2 <= ov1;

      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr3[j][k] <= W'(f_mul(r2[3*k+j], d2[k], W, F));
        end
      end
      r3 <= r2;
      ou3 <= ou2;
      ov3 <= ov2;

      for (int j = 0; j < 3; j++) begin
        cam[j] <= W'(f_add(f_add(pr3[j][0], pr3[j][1], W), pr3[j][2], W));
      end
      bad <= (cz <= 64'sd0);
      rot <= r3;
      obs_u <= ou3;
      obs_v <= ov3;
    end
  end

endmodule

### hdl/rpj_div.sv
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
module rpj_div import rpj_pkg::*; #(
  parameter int W      = 32,
  parameter int F      = 16,
  parameter int LANES  = 2,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic signed [W-1:0] num [LANES],
  input  logic signed [W-1:0] den,
  input  logic [SIDE_W-1:0]   side_in,
  output logic                out_vld,
  output logic signed [W-1:0] quo [LANES],
  output logic [SIDE_W-1:0]   side_out
);

  localparam int NS = W + 1;
  localparam int DW = W + F + 1;

  logic              vld  [NS+1];
  logic [W-1:0]      rem  [NS+1][LANES];
  logic [W:0]        low  [NS+1][LANES];
  logic [W:0]        qt   [NS+1][LANES];
  logic              ovf  [NS+1][LANES];
  logic              ngt  [NS+1][LANES];
  logic [W-1:0]      dm   [NS+1];
  logic [SIDE_W-1:0] sd   [NS+1];

  logic [W-1:0] e_rem [LANES];
  logic [W:0]   e_low [LANES];
  logic         e_ovf [LANES];
  logic         e_ngt [LANES];
  logic [W-1:0] e_dm;
  logic [W-1:0] n_rem [NS][LANES];
  logic [W:0]   n_q   [NS][LANES];

  always_comb begin
    logic [W-1:0]    nm;
    logic [DW-1:0]   dd;
    logic [F-1:0]    top;
    e_dm = den[W-1] ? W'(-den) : W'(den);
    for (int l = 0; l < LANES; l++) begin
      nm  = num[l][W-1] ? W'(-num[l]) : W'(num[l]);
      dd  = {nm, {(F+1){1'b0}}};
      top = dd[DW-1:W+1];
      e_ovf[l] = DW'(top) >= DW'(e_dm);
      e_rem[l] = e_ovf[l] ? '0 : W'(top);
      e_low[l] = dd[W:0];
      e_ngt[l] = num[l][W-1] ^ den[W-1];
    end
  end

  always_comb begin
    logic [W:0] t;
    logic       ge;
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < LANES; l++) begin
        t  = {rem[s][l], low[s][l][W]};
        ge = t >= {1'b0, dm[s]};
        n_rem[s][l] = ge ? W'(t - {1'b0, dm[s]}) : W'(t);
        n_q[s][l]   = {qt[s][l][W-1:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NS; s++) vld[s] <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
      for (int s = 0; s < NS; s++) vld[s+1] <= vld[s];
      out_vld <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    logic [W:0]   qq;
    logic [W+1:0] r;
    if (adv) begin
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= e_rem[l];
        low[0][l] <= e_low[l];
        qt[0][l]  <= '0;
        ovf[0][l] <= e_ovf[l];
        ngt[0][l] <= e_ngt[l];
      end
      dm[0] <= e_dm;
      sd[0] <= side_in;
      for (int s = 0; s < NS; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem[s+1][l] <= n_rem[s][l];
          low[s+1][l] <= low[s][l] << 1;
          qt[s+1][l]  <= n_q[s][l];
          ovf[s+1][l] <= ovf[s][l];
          ngt[s+1][l] <= ngt[s][l];
        end
        dm[s+1] <= dm[s];
        sd[s+1] <= sd[s];
      end
      for (int l = 0; l < LANES; l++) begin
        qq = ovf[NS][l] ? '1 : qt[NS][l];
        r  = ({1'b0, qq} + (W+2)'(1)) >> 1;
        quo[l] <= W'(f_sat(ngt[NS][l] ? -$signed(64'(r)) : $signed(64'(r)), W));
      end
      side_out <= sd[NS];
    end
  end

endmodule

### hdl/rpj_back.sv
// Residual, reduce matrix and Jacobian rows for both image axes, four pipeline stages.
module rpj_back import rpj_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_vld,
  input  logic signed [W-1:0] info [NUM_INFO],
  input  logic signed [W-1:0] iz,
  input  logic signed [W-1:0] eu,
  input  logic signed [W-1:0] ev,
  input  logic signed [W-1:0] uz,
  input  logic signed [W-1:0] vz,
  input  logic signed [W-1:0] rot [9],
  input  logic signed [W-1:0] cam [3],
  input  logic                bad_in,
  output logic                out_vld,
  output logic signed [W-1:0] row_val [2][NUM_COLS],
  output logic                bad
);

  logic v1, v2, v3;
  logic signed [63:0] b0, b1;
  logic signed [W-1:0] p_r0 [2], p_r1 [2], p_ra [2], p_rb [2], p_ea [2], p_eb [2];
  logic signed [W-1:0] red [2][3];
  logic signed [W-1:0] res2 [2], res3 [2];
  logic signed [W-1:0] mm [2][3][3];
  logic signed [W-1:0] xp [2][6];
  logic signed [W-1:0] rot1 [9], rot2 [9];
  logic signed [W-1:0] cam1 [3], cam2 [3];
  logic bad1, bad2, bad3;
  logic signed [63:0] m [2][3];

  assign b0 = f_neg(uz, W);
  assign b1 = f_neg(vz, W);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      out_vld <= v3;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j] = f_add(f_add(mm[i][j][0], mm[i][j][1], W), mm[i][j][2], W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        p_r0[i] <= W'(f_mul(info[2*i], iz, W, F));
        p_r1[i] <= W'(f_mul(info[2*i+1], iz, W, F));
        p_ra[i] <= W'(f_mul(info[2*i], b0, W, F));
        p_rb[i] <= W'(f_mul(info[2*i+1], b1, W, F));
        p_ea[i] <= W'(f_mul(info[2*i], eu, W, F));
        p_eb[i] <= W'(f_mul(info[2*i+1], ev, W, F));
      end
      rot1 <= rot;
      cam1 <= cam;
      bad1 <= bad_in;

      for (int i = 0; i < 2; i++) begin
        red[i][0] <= p_r0[i];
        red[i][1] <= p_r1[i];
        red[i][2] <= W'(f_add(p_ra[i], p_rb[i], W));
        res2[i]   <= W'(f_add(p_ea[i], p_eb[i], W));
      end
      rot2 <= rot1;
      cam2 <= cam1;
      bad2 <= bad1;

      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            mm[i][j][k] <= W'(f_mul(red[i][k], rot2[3*j+k], W, F));
          end
        end
        xp[i][0] <= W'(f_mul(red[i][1], cam2[2], W, F));
        xp[i][1] <= W'(f_mul(red[i][2], cam2[1], W, F));
        xp[i][2] <= W'(f_mul(red[i][2], cam2[0], W, F));
        xp[i][3] <= W'(f_mul(red[i][0], cam2[2], W, F));
        xp[i][4] <= W'(f_mul(red[i][0], cam2[1], W, F));
        xp[i][5] <= W'(f_mul(red[i][1], cam2[0], W, F));
        res3[i]  <= res2[i];
      end
      bad3 <= bad2;

      for (int i = 0; i < 2; i++) begin
        row_val[i][0] <= res3[i];
        for (int j = 0; j < 3; j++) begin
          row_val[i][1+j] <= W'(f_neg(m[i][j], W));
          row_val[i][7+j] <= W'(m[i][j]);
        end
        row_val[i][4] <= W'(f_sub(xp[i][0], xp[i][1], W));
        row_val[i][5] <= W'(f_sub(xp[i][2], xp[i][3], W));
        row_val[i][6] <= W'(f_sub(xp[i][4], xp[i][5], W));
      end
      bad <= bad3;
    end
  end

endmodule

### verif/tb_top.sv
// Testbench for the pinhole reprojection residual and Jacobian core.
`timescale 1ns / 1ps
module tb_top;
  import rpj_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam longint HI = 64'sd2147483647;
  localparam longint LO = -64'sd2147483648;
  localparam int DRAIN = 2 * W + 40;
  localparam int WATCH_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] tx, ty, tz;
    logic signed [17:0] qx, qy, qz, qw;
    logic signed [31:0] px, py, pz, ou, ov;
  } obs_t;

  typedef struct {
    logic signed [31:0] col [10];
    logic               bad;
    logic               lastr;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] cam_pos_x = 0, cam_pos_y = 0, cam_pos_z = 0;
  logic signed [17:0] quat_x = 0, quat_y = 0, quat_z = 0, quat_w = 0;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0, observed_u = 0, observed_v = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] residual, pose_jac_tx, pose_jac_ty, pose_jac_tz;
  logic signed [31:0] pose_jac_rx, pose_jac_ry, pose_jac_rz;
  logic signed [31:0] point_jac_x, point_jac_y, point_jac_z;
  logic depth_invalid, last_row;

  string col_name [10] = '{"residual", "pose_jac_tx", "pose_jac_ty", "pose_jac_tz",
                           "pose_jac_rx", "pose_jac_ry", "pose_jac_rz",
                           "point_jac_x", "point_jac_y", "point_jac_z"};

  longint info_m [2][2];
  row_t expected_rows [$];
  int fails = 0;
  int sent = 0, rows_seen = 0, bad_depth = 0;
  int idle_pct = 13;
  int quiet = 0;

  pinhole_reprojection_residual_jacobian_core dut (.*);

  initial forever #1 clk = ~clk;

  function automatic longint clip(longint x);
    return x > HI ? HI : (x < LO ? LO : x);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint ua, ub, r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    r = (ua * ub + (64'sd1 << (FB - 1))) >>> FB;
    return clip(((a < 0) != (b < 0)) ? -r : r);
  endfunction

  function automatic longint fx_div(longint a, longint b);
    longint ua, ub, q;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    q = ((ua << (FB + 1)) / ub + 1) >>> 1;
    return clip(((a < 0) != (b < 0)) ? -q : q);
  endfunction

  function automatic longint fx_dot3(longint a, longint b, longint c, longint d,
                                     longint e, longint f);
    return clip(clip(fx_mul(a, b) + fx_mul(c, d)) + fx_mul(e, f));
  endfunction

  task automatic project_observation(input obs_t o);
    longint r [3][3];
    longint c [3], dd [3], m [3], red [3];
    longint qx, qy, qz, qw, one, z, iz, u, v, eu, ev, b0, b1;
    row_t rw;
    qx = longint'(o.qx); qy = longint'(o.qy); qz = longint'(o.qz); qw = longint'(o.qw);
    one = 64'sd1 << FB;
    r[0][0] = clip(one - clip(2 * clip(fx_mul(qy, qy) + fx_mul(qz, qz))));
    r[0][1] = clip(2 * clip(fx_mul(qx, qy) - fx_mul(qz, qw)));
    r[0][2] = clip(2 * clip(fx_mul(qx, qz) + fx_mul(qy, qw)));
    r[1][0] = clip(2 * clip(fx_mul(qx, qy) + fx_mul(qz, qw)));
    r[1][1] = clip(one - clip(2 * clip(fx_mul(qx, qx) + fx_mul(qz, qz))));
    r[1][2] = clip(2 * clip(fx_mul(qy, qz) - fx_mul(qx, qw)));
    r[2][0] = clip(2 * clip(fx_mul(qx, qz) - fx_mul(qy, qw)));
    r[2][1] = clip(2 * clip(fx_mul(qy, qz) + fx_mul(qx, qw)));
    r[2][2] = clip(one - clip(2 * clip(fx_mul(qx, qx) + fx_mul(qy, qy))));
    dd[0] = clip(longint'(o.px) - o.tx);
    dd[1] = clip(longint'(o.py) - o.ty);
    dd[2] = clip(longint'(o.pz) - o.tz);
    for (int j = 0; j < 3; j++)
      c[j] = fx_dot3(r[0][j], dd[0], r[1][j], dd[1], r[2][j], dd[2]);
    z = c[2];
    if (z <= 0) begin
      bad_depth++;
      for (int i = 0; i < 2; i++) begin
        foreach (rw.col[k]) rw.col[k] = HI[31:0];
        rw.bad = 1;
        rw.lastr = i[0];
        expected_rows.push_back(rw);
      end
      return;
    end
    iz = fx_div(one, z);
    u = fx_div(c[0], z);
    v = fx_div(c[1], z);
    eu = clip(u - longint'(o.ou));
    ev = clip(v - longint'(o.ov));
    b0 = clip(-fx_div(u, z));
    b1 = clip(-fx_div(v, z));
    for (int i = 0; i < 2; i++) begin
      red[0] = fx_mul(info_m[i][0], iz);
      red[1] = fx_mul(info_m[i][1], iz);
      red[2] = clip(fx_mul(info_m[i][0], b0) + fx_mul(info_m[i][1], b1));
      for (int j = 0; j < 3; j++)
        m[j] = fx_dot3(red[0], r[j][0], red[1], r[j][1], red[2], r[j][2]);
      rw.col[0] = 32'(clip(fx_mul(info_m[i][0], eu) + fx_mul(info_m[i][1], ev)));
      rw.col[1] = 32'(clip(-m[0]));
      rw.col[2] = 32'(clip(-m[1]));
      rw.col[3] = 32'(clip(-m[2]));
      rw.col[4] = 32'(clip(fx_mul(red[1], c[2]) - fx_mul(red[2], c[1])));
      rw.col[5] = 32'(clip(fx_mul(red[2], c[0]) - fx_mul(red[0], c[2])));
      rw.col[6] = 32'(clip(fx_mul(red[0], c[1]) - fx_mul(red[1], c[0])));
      for (int j = 0; j < 3; j++) rw.col[7 + j] = 32'(m[j]);
      rw.bad = 0;
      rw.lastr = i[0];
      expected_rows.push_back(rw);
    end
  endtask

  task automatic write_info(input logic [1:0] idx, input logic signed [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    info_m[idx[1]][idx[0]] = longint'(val);
  endtask

  task automatic send_observation(input obs_t o);
    while (($urandom_range(99) < idle_pct)) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cam_pos_x <= o.tx; cam_pos_y <= o.ty; cam_pos_z <= o.tz;
    quat_x <= o.qx; quat_y <= o.qy; quat_z <= o.qz; quat_w <= o.qw;
    point_x <= o.px; point_y <= o.py; point_z <= o.pz;
    observed_u <= o.ou; observed_v <= o.ov;
    project_observation(o);
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain_rows();
    int guard = 0;
    in_valid <= 0;
    while (expected_rows.size() != 0 && guard < WATCH_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd32();
    case ($urandom_range(5))
      0: return HI[31:0];
      1: return LO[31:0];
      2: return $signed($urandom_range(0, 20)) <<< FB;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [17:0] rnd_q();
    case ($urandom_range(3))
      0: return 18'sd65536;
      1: return -18'sd65536;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Camera looking down +z at a point in front of it, unit quaternion close to identity.
  function automatic obs_t rnd_good();
    obs_t o;
    int ang;
    o.tx = $signed($urandom_range(0, 40 << FB)) - (20 <<< FB);
    o.ty = $signed($urandom_range(0, 40 << FB)) - (20 <<< FB);
    o.tz = $signed($urandom_range(0, 40 << FB)) - (20 <<< FB);
    ang = $urandom_range(0, 20000);
    o.qx = 0; o.qy = 0; o.qz = 0; o.qw = 18'sd65536;
    case ($urandom_range(3))
      0: begin
        o.qx = 18'(ang - 10000);
        o.qw = 18'(65536 - (ang - 10000) * (ang - 10000) / 131072);
      end
      1: begin
        o.qy = 18'(ang - 10000);
        o.qw = 18'(65536 - (ang - 10000) * (ang - 10000) / 131072);
      end
      2: begin
        o.qz = 18'(ang - 10000);
        o.qw = 18'(65536 - (ang - 10000) * (ang - 10000) / 131072);
      end
      default: ;
    endcase
    o.px = o.tx + $signed($urandom_range(0, 20 << FB)) - (10 <<< FB);
    o.py = o.ty + $signed($urandom_range(0, 20 << FB)) - (10 <<< FB);
    o.pz = o.tz + $signed($urandom_range(1 << 12, 30 << FB));
    o.ou = $signed($urandom_range(0, 4 << FB)) - (2 <<< FB);
    o.ov = $signed($urandom_range(0, 4 << FB)) - (2 <<< FB);
    return o;
  endfunction

  function automatic obs_t rnd_wild();
    obs_t o;
    o.tx = rnd32(); o.ty = rnd32(); o.tz = rnd32();
    o.qx = rnd_q(); o.qy = rnd_q(); o.qz = rnd_q(); o.qw = rnd_q();
    o.px = rnd32(); o.py = rnd32(); o.pz = rnd32();
    o.ou = rnd32(); o.ov = rnd32();
    return o;
  endfunction

  task automatic test_directed();
    obs_t o;
    o = rnd_good();
    o.qx = 0; o.qy = 0; o.qz = 0; o.qw = 18'sd65536;
    o.tx = 0; o.ty = 0; o.tz = 0; o.px = 1 <<< FB; o.py = -(2 <<< FB); o.pz = 4 <<< FB;
    o.ou = 0; o.ov = 0;
    send_observation(o);
    o.pz = 0;
    send_observation(o);
    o.pz = -(3 <<< FB);
    send_observation(o);
    o.pz = 1;
    send_observation(o);
    o.pz = 4 <<< FB; o.ou = HI[31:0]; o.ov = LO[31:0];
    send_observation(o);
    o.tx = LO[31:0]; o.ty = HI[31:0]; o.tz = LO[31:0];
    o.px = HI[31:0]; o.py = LO[31:0]; o.pz = HI[31:0];
    send_observation(o);
    o.qx = 18'sd65536; o.qy = -18'sd65536; o.qz = 18'sd65536; o.qw = -18'sd65536;
    send_observation(o);
    o.qx = 18'sh1FFFF; o.qy = 18'sh20000; o.qz = 18'sh3FFFF; o.qw = 0;
    send_observation(o);
    o = rnd_good(); o.qx = 0; o.qy = 0; o.qz = 0; o.qw = 0;
    send_observation(o);
    for (int k = 0; k < 12; k++) send_observation(rnd_good());
    drain_rows();
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++)
      send_observation(($urandom_range(99) < 80) ? rnd_good() : rnd_wild());
    drain_rows();
  endtask

  task automatic test_info_settings();
    write_info(IDX_INFO_00, HI[31:0]);
    write_info(IDX_INFO_01, LO[31:0]);
    write_info(IDX_INFO_10, LO[31:0]);
    write_info(IDX_INFO_11, HI[31:0]);
    test_random(100);
    write_info(IDX_INFO_00, 0);
    write_info(IDX_INFO_01, 0);
    write_info(IDX_INFO_10, 0);
    write_info(IDX_INFO_11, 0);
    test_random(100);
    for (int s = 0; s < 4; s++) begin
      write_info(IDX_INFO_00, $signed($urandom_range(0, 8 << FB)) - (4 <<< FB));
      write_info(IDX_INFO_01, $signed($urandom_range(0, 2 << FB)) - (1 <<< FB));
      write_info(IDX_INFO_10, (s == 3) ? $urandom : $signed($urandom_range(0, 1 << FB)));
      write_info(IDX_INFO_11, $signed($urandom_range(0, 8 << FB)) - (4 <<< FB));
      test_random(250);
    end
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    test_random(150);
    idle_pct = 13;
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= (idle_pct != 0) && ($urandom_range(99) < 13);
  end

  always @(posedge clk) begin
    row_t e;
    logic signed [31:0] got [10];
    if (!rst && out_valid && !out_stall) begin
      got = '{residual, pose_jac_tx, pose_jac_ty, pose_jac_tz, pose_jac_rx, pose_jac_ry,
              pose_jac_rz, point_jac_x, point_jac_y, point_jac_z};
      rows_seen++;
      if (expected_rows.size() == 0) begin
        $error("result row with no observation outstanding");
        fails++;
      end else begin
        e = expected_rows.pop_front();
        for (int k = 0; k < 10; k++)
          if (got[k] !== e.col[k]) begin
            $error("%s: expected %0d, got %0d", col_name[k], e.col[k], got[k]);
            fails++;
          end
        if (depth_invalid !== e.bad) begin
          $error("depth_invalid: expected %0b, got %0b", e.bad, depth_invalid);
          fails++;
        end
        if (last_row !== e.lastr) begin
          $error("last_row: expected %0b, got %0b", e.lastr, last_row);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet <= 0;
    else if (expected_rows.size() != 0 || in_valid) begin
      quiet <= quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("** pinhole_reprojection_residual_jacobian_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    info_m[0][0] = 65536; info_m[0][1] = 0; info_m[1][0] = 0; info_m[1][1] = 65536;
    repeat (6) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(300);
    test_no_idle();
    test_info_settings();
    if (expected_rows.size() != 0) begin
      $error("%0d result rows never arrived", expected_rows.size());
      fails++;
    end
    $display("Covered %0d observations, %0d rows checked, %0d behind the camera,",
             sent, rows_seen, bad_depth);
    $display("over identity, extreme, zero and random information matrices.");
    if (fails == 0) $display("** pinhole_reprojection_residual_jacobian_core: PASSED **");
    else $display("** pinhole_reprojection_residual_jacobian_core: FAILED **");
    $finish;
  end
endmodule

### sim.f
hdl/rpj_pkg.sv
hdl/rpj_cfg.sv
hdl/rpj_front.sv
hdl/rpj_div.sv
hdl/rpj_back.sv
hdl/pinhole_reprojection_residual_jacobian_core.sv
verif/tb_top.sv
